// ===== hdl/rbd_pkg.sv =====
// rbd_pkg: command and status codes plus the control and status structs
// shared by the ring buffer deque controller, datapath and top level
// no dependencies
package rbd_pkg;

	typedef logic [1:0] cmd_code_t;
	typedef logic [1:0] status_code_t;

	localparam cmd_code_t CMD_PUSH_FRONT = 2'd0;
	localparam cmd_code_t CMD_PUSH_REAR  = 2'd1;
	localparam cmd_code_t CMD_POP_FRONT  = 2'd2;
	localparam cmd_code_t CMD_POP_REAR   = 2'd3;

	localparam status_code_t STATUS_OK         = 2'd0;
	localparam status_code_t STATUS_FULL       = 2'd1;
	localparam status_code_t STATUS_EMPTY      = 2'd2;
	localparam status_code_t STATUS_UNUSED     = 2'd3;

	localparam int unsigned CMD_W      = 2;
	localparam int unsigned PORT_DATA_W = 32;
	localparam int unsigned CAP_W      = 7;
	localparam int unsigned OCC_W      = 7;

	// controller to datapath
	typedef struct packed {
		logic         rd_en;
		logic         rd_rear;
		logic         rear;
		logic         exec;
		logic         push;
		logic         pop;
		status_code_t status;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

endpackage

// ===== hdl/ring_buffer_deque.sv =====
// ring_buffer_deque: top level of the double-ended queue over a circular store
// instantiates rbd_ctrl and rbd_datapath, depends on rbd_pkg
//
// A command is taken when start is high and busy is low; busy then stays high
// for one cycle and the result appears with done for exactly one cycle on the
// following cycle. The result cannot be held off and a new command may be taken
// in the cycle its predecessor's result is shown. Pushes into a full queue and
// pops from an empty one return a status code and leave the queue untouched.
// Capacity is written through cfg_valid/cfg_ready while no command is active;
// zero acts as one and values above DEPTH act as DEPTH.
module ring_buffer_deque #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  rbd_pkg::cmd_code_t                 cmd,
	input  logic [rbd_pkg::PORT_DATA_W-1:0]    push_value,
	output logic                               done,
	output logic [rbd_pkg::PORT_DATA_W-1:0]    pop_value,
	output logic                               pop_valid,
	output rbd_pkg::status_code_t              status,
	output logic [rbd_pkg::OCC_W-1:0]          occupancy,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rbd_pkg::CAP_W-1:0]          cfg_data
);

	rbd_pkg::ctl_t     ctl;
	rbd_pkg::dp_stat_t dp_stat;
	logic              cfg_we;

	assign cfg_we = cfg_valid && cfg_ready;

	rbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.dp_stat   (dp_stat),
		.ctl       (ctl),
		.busy      (busy),
		.done      (done),
		.cfg_ready (cfg_ready)
	);

	rbd_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.dp_stat    (dp_stat),
		.push_value (push_value),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.pop_value  (pop_value),
		.pop_valid  (pop_valid),
		.status     (status),
		.occupancy  (occupancy)
	);

endmodule

// ===== hdl/rbd_ctrl.sv =====
// rbd_ctrl: two-state sequencer that takes a request, decides push/pop
// outcome from the datapath flags and raises the done strobe
// depends on rbd_pkg
module rbd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  rbd_pkg::cmd_code_t   cmd,
	input  rbd_pkg::dp_stat_t    dp_stat,
	output rbd_pkg::ctl_t        ctl,
	output logic                 busy,
	output logic                 done,
	output logic                 cfg_ready
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic               state_q;
	logic               done_q;
	rbd_pkg::cmd_code_t cmd_q;
	logic               accept;
	logic               is_push;
	logic               is_rear;

	assign busy      = (state_q == ST_EXEC);
	assign accept    = start && !busy;
	assign done      = done_q;
	assign cfg_ready = !busy;

	assign is_push = (cmd_q == rbd_pkg::CMD_PUSH_FRONT) || (cmd_q == rbd_pkg::CMD_PUSH_REAR);
	assign is_rear = (cmd_q == rbd_pkg::CMD_PUSH_REAR) || (cmd_q == rbd_pkg::CMD_POP_REAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= busy;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
	end

	always_comb begin
		ctl.rd_en   = accept;
		ctl.rd_rear = (cmd == rbd_pkg::CMD_POP_REAR);
		ctl.rear    = is_rear;
		ctl.exec    = busy;
		ctl.push    = busy && is_push && !dp_stat.full;
		ctl.pop     = busy && !is_push && !dp_stat.empty;
		priority if (is_push && dp_stat.full) begin
			ctl.status = rbd_pkg::STATUS_FULL;
		end else if (!is_push && dp_stat.empty) begin
			ctl.status = rbd_pkg::STATUS_EMPTY;
		end else begin
			ctl.status = rbd_pkg::STATUS_OK;
		end
	end

`ifndef SYNTH
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not enter execution");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("execution did not end with a done strobe");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe longer than one cycle");
`endif

endmodule

// ===== hdl/rbd_datapath.sv =====
// rbd_datapath: circular store, front/rear pointers, held count, capacity
// register and result registers of the ring buffer deque
// depends on rbd_pkg
module rbd_datapath #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rbd_pkg::ctl_t                      ctl,
	output rbd_pkg::dp_stat_t                  dp_stat,
	input  logic [rbd_pkg::PORT_DATA_W-1:0]    push_value,
	input  logic                               cfg_we,
	input  logic [rbd_pkg::CAP_W-1:0]          cfg_data,
	output logic [rbd_pkg::PORT_DATA_W-1:0]    pop_value,
	output logic                               pop_valid,
	output rbd_pkg::status_code_t              status,
	output logic [rbd_pkg::OCC_W-1:0]          occupancy
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned AW = CW + 1;
	localparam int unsigned XW = (CW > rbd_pkg::CAP_W) ? CW : rbd_pkg::CAP_W;
	localparam int unsigned SW = (DATA_WIDTH < rbd_pkg::PORT_DATA_W) ? DATA_WIDTH
		: rbd_pkg::PORT_DATA_W;
	localparam logic [rbd_pkg::CAP_W-1:0] CAP_RESET = 7'd64;

	logic [SW-1:0] mem [DEPTH];
	logic [SW-1:0] rdata_q;
	logic [SW-1:0] wdata_q;
	logic [PW-1:0] front_q;
	logic [PW-1:0] rear_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] cap_q;
	logic [PW-1:0] slot;
	logic [CW-1:0] count_next;
	logic [rbd_pkg::PORT_DATA_W-1:0] pop_value_q;
	logic          pop_valid_q;
	rbd_pkg::status_code_t status_q;
	logic [rbd_pkg::OCC_W-1:0] occupancy_q;

	function automatic logic [CW-1:0] eff_cap(input logic [rbd_pkg::CAP_W-1:0] v);
		logic [XW-1:0] x;
		x = XW'(v);
		if (x == '0) begin
			x = XW'(1);
		end else if (x > XW'(DEPTH)) begin
			x = XW'(DEPTH);
		end
		return CW'(x);
	endfunction

	function automatic logic [PW-1:0] step_up(input logic [PW-1:0] idx,
		input logic [CW-1:0] cap);
		logic [AW-1:0] up;
		up = AW'(idx) + AW'(1);
		if (up >= AW'(cap)) begin
			return '0;
		end
		return PW'(up);
	endfunction

	function automatic logic [PW-1:0] step_down(input logic [PW-1:0] idx,
		input logic [CW-1:0] cap);
		if ((idx == '0) || (AW'(idx) > AW'(cap))) begin
			return PW'(AW'(cap) - AW'(1));
		end
		return PW'(AW'(idx) - AW'(1));
	endfunction

	assign dp_stat.full  = (count_q >= cap_q);
	assign dp_stat.empty = (count_q == '0);

	always_comb begin
		if (ctl.rear) begin
			slot = dp_stat.empty ? rear_q : step_up(rear_q, cap_q);
		end else begin
			slot = dp_stat.empty ? front_q : step_down(front_q, cap_q);
		end
	end

	always_comb begin
		priority if (ctl.push) begin
			count_next = count_q + CW'(1);
		end else if (ctl.pop) begin
			count_next = count_q - CW'(1);
		end else begin
			count_next = count_q;
		end
	end

	// store, read registered
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[slot] <= wdata_q;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[ctl.rd_rear ? rear_q : front_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			wdata_q <= SW'(push_value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
			cap_q   <= eff_cap(CAP_RESET);
		end else begin
			if (cfg_we) begin
				cap_q <= eff_cap(cfg_data);
			end
			count_q <= count_next;
			if (ctl.push) begin
				if (ctl.rear) begin
					rear_q <= slot;
				end else begin
					front_q <= slot;
				end
			end
			if (ctl.pop && (front_q != rear_q)) begin
				if (ctl.rear) begin
					rear_q <= step_down(rear_q, cap_q);
				end else begin
					front_q <= step_up(front_q, cap_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			pop_value_q <= ctl.pop ? rbd_pkg::PORT_DATA_W'(rdata_q) : '0;
			pop_valid_q <= ctl.pop;
			status_q    <= ctl.status;
			occupancy_q <= rbd_pkg::OCC_W'(count_next);
		end
	end

	assign pop_value = pop_value_q;
	assign pop_valid = pop_valid_q;
	assign status    = status_q;
	assign occupancy = occupancy_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		AW'(count_q) <= AW'(DEPTH))
		else $error("held count beyond store depth");
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.push, ctl.pop}))
		else $error("push and pop in the same cycle");
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec && !ctl.push && !ctl.pop && !cfg_we) |=> $stable(count_q))
		else $error("rejected request changed the held count");
`endif

endmodule
